[sv/ssfa_pkg.sv]
package ssfa_pkg;

  localparam int FRAC_BITS     = 16;
  localparam int MAX_SHEET_DIM = 64;

  localparam int SHEET_W = 7;
  localparam int DIM_W   = $clog2(MAX_SHEET_DIM + 1);
  localparam int IDX_W   = $clog2(MAX_SHEET_DIM);
  localparam int FRAME_W = $clog2(MAX_SHEET_DIM * MAX_SHEET_DIM);
  localparam int RC_W    = FRAME_W + 1;
  localparam int DUR_W   = 24;
  localparam int DELTA_W = 24;
  localparam int TIME_W  = RC_W + DUR_W;
  localparam int UV_W    = 16;
  localparam int EXT_W   = UV_W + 1;
  localparam int DIV_W   = TIME_W;
  localparam int CNT_W   = $clog2(DIV_W + 1);
  localparam int CFG_W   = 24;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_ROWS    = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_COLUMNS = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_FRAME   = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_LOOP    = CFG_IDX_W'(3);

  localparam logic [DUR_W-1:0] DUR_ONE = DUR_W'(1) << FRAC_BITS;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [DIV_W-1:0] divisor;
    logic [CNT_W-1:0] steps;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quotient;
    logic [DIV_W-1:0] remainder;
  } div_rsp_t;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [SHEET_W-1:0] v);
    logic [DIM_W-1:0] r;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (int'(v) > MAX_SHEET_DIM) begin
      r = DIM_W'(MAX_SHEET_DIM);
    end else begin
      r = DIM_W'(v);
    end
    return r;
  endfunction

endpackage

[sv/ssfa_div.sv]
// Restoring divider, one quotient bit per cycle. The caller guarantees
// dividend >> steps < divisor, so steps bits of quotient suffice.
module ssfa_div (
  input  logic               clk,
  input  logic               rst,
  input  ssfa_pkg::div_req_t req,
  output ssfa_pkg::div_rsp_t rsp
);

  logic [ssfa_pkg::CNT_W-1:0] cnt;
  logic [ssfa_pkg::DIV_W-1:0] rem;
  logic [ssfa_pkg::DIV_W-1:0] quo;
  logic [ssfa_pkg::DIV_W-1:0] dsr;
  logic                       done;

  logic [ssfa_pkg::DIV_W:0] shifted;
  logic [ssfa_pkg::DIV_W:0] diff;
  logic                     fits;

  assign shifted = {rem, quo[ssfa_pkg::DIV_W-1]};
  assign fits    = shifted >= {1'b0, dsr};
  assign diff    = shifted - {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= (cnt == ssfa_pkg::CNT_W'(1));
      if (req.start) begin
        cnt <= req.steps;
      end else if (cnt != '0) begin
        cnt <= cnt - ssfa_pkg::CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= req.dividend >> req.steps;
      quo <= req.dividend << (ssfa_pkg::CNT_W'(ssfa_pkg::DIV_W) - req.steps);
      dsr <= req.divisor;
    end else if (cnt != '0) begin
      rem <= fits ? diff[ssfa_pkg::DIV_W-1:0] : shifted[ssfa_pkg::DIV_W-1:0];
      quo <= {quo[ssfa_pkg::DIV_W-2:0], fits};
    end
  end

  assign rsp.done      = done;
  assign rsp.quotient  = quo;
  assign rsp.remainder = rem;

  a_rem_below_divisor: assert property (@(posedge clk) disable iff (rst)
    done |-> rem < dsr) else $error("divider remainder not below divisor");

  a_start_when_free: assert property (@(posedge clk) disable iff (rst)
    req.start |-> cnt == '0) else $error("divider started while busy");

  a_done_after_last: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(cnt) == ssfa_pkg::CNT_W'(1)) else $error("divider done out of turn");

endmodule

[sv/sprite_sheet_frame_animator_unit.sv]
// A tick steps through S_MUL, S_END and S_CHECK, then S_MOD when the time point wraps, the
// divisions S_FRAME to S_VEXT and S_OUT; a tick that ends a non-looping animation returns to idle from S_CHECK.
// A new tick is taken only in S_IDLE, once the last one has left S_OUT; the shared
// 1-bit-per-cycle divider runs six or seven divisions per item.
// Reset (rst, synchronous): sheet 1x1, frame length 1.0 s, looping off, time point 0.
module sprite_sheet_frame_animator_unit (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             tick_valid,
  output logic                             tick_ready,
  input  logic [ssfa_pkg::DELTA_W-1:0]     delta_time,
  output logic                             result_valid,
  input  logic                             result_ready,
  output logic [ssfa_pkg::FRAME_W-1:0]     frame_index,
  output logic [ssfa_pkg::IDX_W-1:0]       frame_column,
  output logic [ssfa_pkg::IDX_W-1:0]       frame_row,
  output logic [ssfa_pkg::UV_W-1:0]        u_origin,
  output logic [ssfa_pkg::UV_W-1:0]        v_origin,
  output logic [ssfa_pkg::EXT_W-1:0]       u_extent,
  output logic [ssfa_pkg::EXT_W-1:0]       v_extent,
  input  logic                             cfg_write,
  input  logic [ssfa_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ssfa_pkg::CFG_W-1:0]       cfg_data
);

  typedef enum logic [11:0] {
    S_IDLE  = 12'b0000_0000_0001,
    S_MUL   = 12'b0000_0000_0010,
    S_END   = 12'b0000_0000_0100,
    S_CHECK = 12'b0000_0000_1000,
    S_MOD   = 12'b0000_0001_0000,
    S_FRAME = 12'b0000_0010_0000,
    S_SPLIT = 12'b0000_0100_0000,
    S_UORG  = 12'b0000_1000_0000,
    S_VORG  = 12'b0001_0000_0000,
    S_UEXT  = 12'b0010_0000_0000,
    S_VEXT  = 12'b0100_0000_0000,
    S_OUT   = 12'b1000_0000_0000
  } state_t;

  state_t state;
  logic   issued;

  logic [ssfa_pkg::SHEET_W-1:0] sheet_rows;
  logic [ssfa_pkg::SHEET_W-1:0] sheet_columns;
  logic [ssfa_pkg::DUR_W-1:0]   frame_length;
  logic                         loop_enable;

  logic [ssfa_pkg::DELTA_W-1:0] delta;
  logic [ssfa_pkg::DIM_W-1:0]   rows;
  logic [ssfa_pkg::DIM_W-1:0]   cols;
  logic [ssfa_pkg::DUR_W-1:0]   dur;
  logic [ssfa_pkg::RC_W-1:0]    rc;
  logic [ssfa_pkg::TIME_W-1:0]  end_time;
  logic [ssfa_pkg::TIME_W-1:0]  time_point;
  logic [ssfa_pkg::FRAME_W-1:0] frame;
  logic [ssfa_pkg::IDX_W-1:0]   col;
  logic [ssfa_pkg::IDX_W-1:0]   row;
  logic [ssfa_pkg::UV_W-1:0]    u_org;
  logic [ssfa_pkg::UV_W-1:0]    v_org;
  logic [ssfa_pkg::EXT_W-1:0]   u_ext;
  logic [ssfa_pkg::EXT_W-1:0]   v_ext;

  logic [2*ssfa_pkg::DIM_W-1:0]             rc_prod;
  logic [ssfa_pkg::RC_W+ssfa_pkg::DUR_W-1:0] end_prod;
  logic [ssfa_pkg::TIME_W-1:0]              raw;
  logic                                     div_state;

  ssfa_pkg::div_req_t div_req;
  ssfa_pkg::div_rsp_t div_rsp;

  assign rc_prod  = rows * cols;
  assign end_prod = rc * dur;
  assign raw      = time_point + ssfa_pkg::TIME_W'(delta);
  assign tick_ready = (state == S_IDLE);

  assign div_state = (state == S_MOD) || (state == S_FRAME) || (state == S_SPLIT) ||
                     (state == S_UORG) || (state == S_VORG) || (state == S_UEXT) ||
                     (state == S_VEXT);

  always_comb begin
    div_req.start    = div_state && !issued;
    div_req.dividend = '0;
    div_req.divisor  = '0;
    div_req.steps    = '0;
    case (state)
      S_MOD: begin
        div_req.dividend = raw;
        div_req.divisor  = end_time;
        div_req.steps    = ssfa_pkg::CNT_W'(ssfa_pkg::DIV_W);
      end
      S_FRAME: begin
        div_req.dividend = time_point;
        div_req.divisor  = ssfa_pkg::DIV_W'(dur);
        div_req.steps    = ssfa_pkg::CNT_W'(ssfa_pkg::FRAME_W);
      end
      S_SPLIT: begin
        div_req.dividend = ssfa_pkg::DIV_W'(frame);
        div_req.divisor  = ssfa_pkg::DIV_W'(cols);
        div_req.steps    = ssfa_pkg::CNT_W'(ssfa_pkg::DIM_W);
      end
      S_UORG: begin
        div_req.dividend = ssfa_pkg::DIV_W'(col) << ssfa_pkg::UV_W;
        div_req.divisor  = ssfa_pkg::DIV_W'(cols);
        div_req.steps    = ssfa_pkg::CNT_W'(ssfa_pkg::UV_W);
      end
      S_VORG: begin
        div_req.dividend = ssfa_pkg::DIV_W'(row) << ssfa_pkg::UV_W;
        div_req.divisor  = ssfa_pkg::DIV_W'(rows);
        div_req.steps    = ssfa_pkg::CNT_W'(ssfa_pkg::UV_W);
      end
      S_UEXT: begin
        div_req.dividend = ssfa_pkg::DIV_W'(1) << ssfa_pkg::UV_W;
        div_req.divisor  = ssfa_pkg::DIV_W'(cols);
        div_req.steps    = ssfa_pkg::CNT_W'(ssfa_pkg::EXT_W);
      end
      S_VEXT: begin
        div_req.dividend = ssfa_pkg::DIV_W'(1) << ssfa_pkg::UV_W;
        div_req.divisor  = ssfa_pkg::DIV_W'(rows);
        div_req.steps    = ssfa_pkg::CNT_W'(ssfa_pkg::EXT_W);
      end
      default: begin
        div_req.start = 1'b0;
      end
    endcase
  end

  ssfa_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      sheet_rows    <= ssfa_pkg::SHEET_W'(1);
      sheet_columns <= ssfa_pkg::SHEET_W'(1);
      frame_length  <= ssfa_pkg::DUR_ONE;
      loop_enable   <= 1'b0;
    end else if (cfg_write) begin
      case (cfg_index)
        ssfa_pkg::REG_ROWS:    sheet_rows    <= cfg_data[ssfa_pkg::SHEET_W-1:0];
        ssfa_pkg::REG_COLUMNS: sheet_columns <= cfg_data[ssfa_pkg::SHEET_W-1:0];
        ssfa_pkg::REG_FRAME:   frame_length  <= cfg_data[ssfa_pkg::DUR_W-1:0];
        ssfa_pkg::REG_LOOP:    loop_enable   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      issued       <= 1'b0;
      time_point   <= '0;
      result_valid <= 1'b0;
    end else begin
      if (state == S_OUT && (!result_valid || result_ready)) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
      if (div_req.start) begin
        issued <= 1'b1;
      end
      if (div_rsp.done) begin
        issued <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (tick_valid) begin
            state <= S_MUL;
          end
        end
        S_MUL: state <= S_END;
        S_END: state <= S_CHECK;
        S_CHECK: begin
          if (raw >= end_time) begin
            state <= loop_enable ? S_MOD : S_IDLE;
          end else begin
            time_point <= raw;
            state      <= S_FRAME;
          end
        end
        S_MOD: begin
          if (div_rsp.done) begin
            time_point <= div_rsp.remainder;
            state      <= S_FRAME;
          end
        end
        S_FRAME: if (div_rsp.done) state <= S_SPLIT;
        S_SPLIT: if (div_rsp.done) state <= S_UORG;
        S_UORG:  if (div_rsp.done) state <= S_VORG;
        S_VORG:  if (div_rsp.done) state <= S_UEXT;
        S_UEXT:  if (div_rsp.done) state <= S_VEXT;
        S_VEXT:  if (div_rsp.done) state <= S_OUT;
        S_OUT: begin
          if (!result_valid || result_ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && tick_valid) begin
      delta <= delta_time;
      rows  <= ssfa_pkg::clamp_dim(sheet_rows);
      cols  <= ssfa_pkg::clamp_dim(sheet_columns);
      dur   <= (frame_length == '0) ? ssfa_pkg::DUR_ONE : frame_length;
    end
    if (state == S_MUL) begin
      rc <= rc_prod[ssfa_pkg::RC_W-1:0];
    end
    if (state == S_END) begin
      end_time <= end_prod;
    end
    if (div_rsp.done) begin
      case (state)
        S_FRAME: frame <= div_rsp.quotient[ssfa_pkg::FRAME_W-1:0];
        S_SPLIT: begin
          col <= div_rsp.remainder[ssfa_pkg::IDX_W-1:0];
          row <= div_rsp.quotient[ssfa_pkg::IDX_W-1:0];
        end
        S_UORG: u_org <= div_rsp.quotient[ssfa_pkg::UV_W-1:0];
        S_VORG: v_org <= div_rsp.quotient[ssfa_pkg::UV_W-1:0];
        S_UEXT: u_ext <= div_rsp.quotient[ssfa_pkg::EXT_W-1:0];
        S_VEXT: v_ext <= div_rsp.quotient[ssfa_pkg::EXT_W-1:0];
        default: ;
      endcase
    end
    if (state == S_OUT && (!result_valid || result_ready)) begin
      frame_index  <= frame;
      frame_column <= col;
      frame_row    <= row;
      u_origin     <= u_org;
      v_origin     <= v_org;
      u_extent     <= u_ext;
      v_extent     <= v_ext;
    end
  end

  a_time_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_FRAME) |-> time_point < end_time) else $error("time point past end");

  a_result_from_out: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(state == S_OUT)) else $error("result raised outside output step");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (tick_valid && tick_ready) |=> !tick_ready) else $error("ready while item in work");

endmodule

[verif/frame_anim_checker.sv]
module frame_anim_checker
  import ssfa_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 tick_valid,
  input  logic                 tick_ready,
  input  logic [DELTA_W-1:0]   delta_time,
  input  logic                 result_valid,
  input  logic                 result_ready,
  input  logic [FRAME_W-1:0]   frame_index,
  input  logic [IDX_W-1:0]     frame_column,
  input  logic [IDX_W-1:0]     frame_row,
  input  logic [UV_W-1:0]      u_origin,
  input  logic [UV_W-1:0]      v_origin,
  input  logic [EXT_W-1:0]     u_extent,
  input  logic [EXT_W-1:0]     v_extent,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  output int                   mismatches,
  output int                   outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [FRAME_W-1:0] frame;
    logic [IDX_W-1:0]   col;
    logic [IDX_W-1:0]   row;
    logic [UV_W-1:0]    u0;
    logic [UV_W-1:0]    v0;
    logic [EXT_W-1:0]   du;
    logic [EXT_W-1:0]   dv;
  } frame_view_t;

  frame_view_t      expected_frames[$];
  logic [SHEET_W-1:0] rows_cfg;
  logic [SHEET_W-1:0] cols_cfg;
  logic [DUR_W-1:0]   frame_len_cfg;
  logic               loop_cfg;
  logic [63:0]        anim_time;
  int                 err_count;

  assign mismatches = err_count;

  function automatic logic [63:0] effective_dim(input logic [SHEET_W-1:0] v);
    if (v == '0) return 64'd1;
    if (v > SHEET_W'(MAX_SHEET_DIM)) return 64'(MAX_SHEET_DIM);
    return 64'(v);
  endfunction

  function automatic void advance_animation(input logic [DELTA_W-1:0] delta);
    logic [63:0] rows, cols, dur, span, moved, frame;
    frame_view_t v;
    rows = effective_dim(rows_cfg);
    cols = effective_dim(cols_cfg);
    dur = (frame_len_cfg == '0) ? (64'd1 << FRAC_BITS) : 64'(frame_len_cfg);
    span = rows * cols * dur;
    moved = anim_time + 64'(delta);
    // end of a one-shot animation: hold, no result
    if (moved >= span && !loop_cfg) return;
    anim_time = moved % span;
    frame = anim_time / dur;
    v.frame = FRAME_W'(frame);
    v.col = IDX_W'(frame % cols);
    v.row = IDX_W'(frame / cols);
    v.u0 = UV_W'(((frame % cols) << UV_W) / cols);
    v.v0 = UV_W'(((frame / cols) << UV_W) / rows);
    v.du = EXT_W'((64'd1 << UV_W) / cols);
    v.dv = EXT_W'((64'd1 << UV_W) / rows);
    expected_frames.push_back(v);
  endfunction

  function automatic void compare_field(input string what, input longint unsigned want,
                                        input longint unsigned got);
    if (want != got) begin
      err_count++;
      $display("%0t frame_anim_checker: %s expected %0d actual %0d", $time, what, want, got);
    end
  endfunction

  always @(posedge clk) begin
    frame_view_t want;
    if (rst) begin
      expected_frames.delete();
      rows_cfg = SHEET_W'(1);
      cols_cfg = SHEET_W'(1);
      frame_len_cfg = DUR_ONE;
      loop_cfg = 1'b0;
      anim_time = '0;
      err_count = 0;
    end else begin
      if (result_valid && result_ready) begin
        if (expected_frames.size() == 0) begin
          err_count++;
          $display("%0t frame_anim_checker: expected no result, actual frame_index %0d",
                   $time, frame_index);
        end else begin
          want = expected_frames.pop_front();
          compare_field("frame_index", want.frame, frame_index);
          compare_field("frame_column", want.col, frame_column);
          compare_field("frame_row", want.row, frame_row);
          compare_field("u_origin", want.u0, u_origin);
          compare_field("v_origin", want.v0, v_origin);
          compare_field("u_extent", want.du, u_extent);
          compare_field("v_extent", want.dv, v_extent);
        end
      end
      if (cfg_write) begin
        case (cfg_index)
          REG_ROWS:    rows_cfg = cfg_data[SHEET_W-1:0];
          REG_COLUMNS: cols_cfg = cfg_data[SHEET_W-1:0];
          REG_FRAME:   frame_len_cfg = cfg_data[DUR_W-1:0];
          REG_LOOP:    loop_cfg = cfg_data[0];
          default: ;
        endcase
      end
      if (tick_valid && tick_ready) advance_animation(delta_time);
    end
    outstanding <= expected_frames.size();
  end

endmodule

[verif/tb_top.sv]
module tb_top
  import ssfa_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int HOLD_CYCLES = 2000;
  localparam int RANDOM_TICKS = 650;

  logic                 clk;
  logic                 rst;
  logic                 tick_valid;
  logic                 tick_ready;
  logic [DELTA_W-1:0]   delta_time;
  logic                 result_valid;
  logic                 result_ready;
  logic [FRAME_W-1:0]   frame_index;
  logic [IDX_W-1:0]     frame_column;
  logic [IDX_W-1:0]     frame_row;
  logic [UV_W-1:0]      u_origin;
  logic [UV_W-1:0]      v_origin;
  logic [EXT_W-1:0]     u_extent;
  logic [EXT_W-1:0]     v_extent;
  logic                 cfg_write;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;
  int                   mismatches;
  int                   outstanding;
  int                   cycles;
  logic                 no_gaps;
  logic                 hold_off_req;

  sprite_sheet_frame_animator_unit dut (
    .clk(clk), .rst(rst),
    .tick_valid(tick_valid), .tick_ready(tick_ready), .delta_time(delta_time),
    .result_valid(result_valid), .result_ready(result_ready),
    .frame_index(frame_index), .frame_column(frame_column), .frame_row(frame_row),
    .u_origin(u_origin), .v_origin(v_origin), .u_extent(u_extent), .v_extent(v_extent),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  frame_anim_checker frame_check (
    .clk(clk), .rst(rst),
    .tick_valid(tick_valid), .tick_ready(tick_ready), .delta_time(delta_time),
    .result_valid(result_valid), .result_ready(result_ready),
    .frame_index(frame_index), .frame_column(frame_column), .frame_row(frame_row),
    .u_origin(u_origin), .v_origin(v_origin), .u_extent(u_extent), .v_extent(v_extent),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .mismatches(mismatches), .outstanding(outstanding)
  );

  initial clk = 1'b0;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  initial cycles = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 4);
    return $urandom_range(10, 60);
  endfunction

  function automatic logic [SHEET_W-1:0] pick_dim();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return '0;
    if (r < 20) return SHEET_W'($urandom_range(65, 127));
    if (r < 35) return ($urandom_range(0, 1) != 0) ? SHEET_W'(64) : SHEET_W'(1);
    return SHEET_W'($urandom_range(1, 64));
  endfunction

  function automatic logic [DUR_W-1:0] pick_frame_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return '0;
    if (r < 20) return DUR_W'($urandom);
    if (r < 28) return '1;
    if (r < 36) return DUR_ONE;
    return DUR_W'($urandom_range(1, 4096));
  endfunction

  function automatic logic [DELTA_W-1:0] pick_delta(input longint unsigned dur);
    int r;
    longint unsigned cap;
    r = $urandom_range(0, 99);
    cap = dur * 3;
    if (cap > 64'hFFFFFF) cap = 64'hFFFFFF;
    if (r < 45) return DELTA_W'($urandom_range(32'(cap), 0));
    if (r < 70) return DELTA_W'($urandom);
    if (r < 80) return '0;
    if (r < 88) return '1;
    return DELTA_W'($urandom_range(0, 15));
  endfunction

  task automatic push_tick(input logic [DELTA_W-1:0] d);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      tick_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    tick_valid <= 1'b1;
    delta_time <= d;
    @(posedge clk);
    while (!tick_ready) @(posedge clk);
  endtask

  // drain all results, then let a resultless tick finish before touching registers
  task automatic settle();
    tick_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic program_sheet(input logic [SHEET_W-1:0] rows, input logic [SHEET_W-1:0] cols,
                               input logic [DUR_W-1:0] flen, input logic looping);
    cfg_write <= 1'b1;
    cfg_index <= REG_ROWS;
    cfg_data <= CFG_W'(rows);
    @(posedge clk);
    cfg_index <= REG_COLUMNS;
    cfg_data <= CFG_W'(cols);
    @(posedge clk);
    cfg_index <= REG_FRAME;
    cfg_data <= CFG_W'(flen);
    @(posedge clk);
    cfg_index <= REG_LOOP;
    cfg_data <= CFG_W'(looping);
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  initial begin
    int gap;
    bit held;
    result_ready = 1'b0;
    held = 1'b0;
    @(posedge clk);
    forever begin
      if (hold_off_req && !held) begin
        held = 1'b1;
        result_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        result_ready <= 1'b1;
        repeat ($urandom_range(1, 16)) @(posedge clk);
        gap = pick_gap();
        if (gap > 0) begin
          result_ready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end
  end

  initial begin
    int counted;
    int n;
    bit hold_issued;
    logic [SHEET_W-1:0] rows;
    logic [SHEET_W-1:0] cols;
    logic [DUR_W-1:0] flen;
    logic looping;
    longint unsigned dur;
    rst = 1'b1;
    tick_valid = 1'b0;
    delta_time = '0;
    cfg_write = 1'b0;
    cfg_index = REG_ROWS;
    cfg_data = '0;
    no_gaps = 1'b0;
    hold_off_req = 1'b0;
    counted = 0;
    hold_issued = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset sheet: 1x1, one second, one-shot
    push_tick('0);
    push_tick(DELTA_W'(65535));
    push_tick(DELTA_W'(1));
    push_tick('1);
    settle();

    // largest sheet, zero frame length, looping
    program_sheet(SHEET_W'(64), SHEET_W'(64), '0, 1'b1);
    repeat (4) push_tick('1);
    push_tick('0);
    push_tick(DELTA_W'(24'h800000));
    settle();

    // rows zero and columns above range, shortest frame, wrap by modulo
    program_sheet('0, SHEET_W'(127), DUR_W'(1), 1'b1);
    push_tick(DELTA_W'(63));
    push_tick(DELTA_W'(1));
    push_tick('1);
    push_tick(DELTA_W'(5));
    settle();

    program_sheet(SHEET_W'(100), '0, '1, 1'b0);
    push_tick('1);
    push_tick('1);
    settle();

    // shrink the animation under the time point: held while one-shot, folded when looping
    program_sheet(SHEET_W'(1), SHEET_W'(1), DUR_W'(1), 1'b0);
    push_tick('0);
    push_tick(DELTA_W'(3));
    settle();
    program_sheet(SHEET_W'(1), SHEET_W'(1), DUR_W'(1), 1'b1);
    push_tick('0);
    push_tick(DELTA_W'(7));

    while (counted < RANDOM_TICKS) begin
      rows = pick_dim();
      cols = pick_dim();
      flen = pick_frame_len();
      looping = ($urandom_range(0, 4) != 0);
      dur = (flen == '0) ? (64'd1 << FRAC_BITS) : 64'(flen);
      settle();
      program_sheet(rows, cols, flen, looping);
      no_gaps <= ($urandom_range(0, 3) == 0);
      n = looping ? $urandom_range(10, 50) : $urandom_range(2, 8);
      if (!hold_issued && looping && counted > 250) begin
        hold_issued = 1'b1;
        hold_off_req <= 1'b1;
        n = 50;
      end
      repeat (n) push_tick(pick_delta(dur));
      if (looping) counted += n;
    end

    settle();
    repeat (150) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
